// File: hdl/qr2_pkg.sv
package qr2_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_Q         = 30;
  localparam int SQRT_STEPS     = 32;
  localparam int DIV_STEPS      = FRAC_Q + 1;
  localparam int P_W            = 35;
  localparam int U_W            = 33;

  typedef struct packed {
    logic signed [31:0] v1x;
    logic signed [31:0] v1y;
    logic signed [31:0] v2x;
    logic signed [31:0] v2y;
  } vec_t;

  typedef struct packed {
    logic [31:0]        n1;
    logic               s1x;
    logic signed [31:0] v2x;
    logic signed [31:0] v2y;
  } d1_side_t;

  typedef struct packed {
    logic [31:0]          mux;
    logic [31:0]          muy;
    logic                 sx;
    logic                 sy;
    logic signed [31:0]   e1x;
    logic signed [31:0]   e1y;
    logic [31:0]          n1;
    logic signed [P_W-1:0] p;
  } s2_side_t;

  typedef struct packed {
    logic                  sx;
    logic signed [31:0]    e1x;
    logic signed [31:0]    e1y;
    logic [31:0]           n1;
    logic [31:0]           n2;
    logic signed [P_W-1:0] p;
  } d2_side_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    mag32 = x[31] ? 32'(-x) : 32'(x);
  endfunction

  // Apply the sign to a quotient magnitude; a zero norm gives zero.
  function automatic logic signed [31:0] unit_fix(input logic neg, input logic [30:0] q,
                                                  input logic zero);
    logic signed [31:0] pos;
    pos = {1'b0, q};
    if (zero) unit_fix = '0;
    else if (neg) unit_fix = -pos;
    else unit_fix = pos;
  endfunction

endpackage

// File: hdl/qr2_sqrt.sv
module qr2_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [63:0]       in_rad,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [31:0]       out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int N = qr2_pkg::SQRT_STEPS;

  logic              valid_r [N];
  logic [63:0]       rad_r   [N];
  logic [33:0]       rem_r   [N];
  logic [31:0]       root_r  [N];
  logic [SIDE_W-1:0] side_r  [N];

  genvar k;
  for (k = 0; k < N; k++) begin : g_step
    logic              v_i;
    logic [63:0]       rad_i;
    logic [33:0]       rem_i;
    logic [31:0]       root_i;
    logic [SIDE_W-1:0] side_i;
    logic [35:0]       rem_sh;
    logic [35:0]       trial;
    logic [35:0]       diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rad_i  = in_rad;
      assign rem_i  = '0;
      assign root_i = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = valid_r[k-1];
      assign rad_i  = rad_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign side_i = side_r[k-1];
    end

    // bring down two radicand bits, try root*4+1
    assign rem_sh = {rem_i, rad_i[63:62]};
    assign trial  = {2'b00, root_i, 2'b01};
    assign diff   = rem_sh - trial;
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= {rad_i[61:0], 2'b00};
        rem_r[k]  <= ge ? diff[33:0] : rem_sh[33:0];
        root_r[k] <= {root_i[30:0], ge};
        side_r[k] <= side_i;
      end
    end
  end

  assign out_valid = valid_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

// File: hdl/qr2_div.sv
module qr2_div #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [31:0]       in_num,
  input  logic [31:0]       in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [30:0]       out_quo,
  output logic [SIDE_W-1:0] out_side
);

  // numerator never exceeds the denominator, so the quotient fits FRAC_Q+1 bits
  localparam int N = qr2_pkg::DIV_STEPS;

  logic              valid_r [N];
  logic [31:0]       rem_r   [N];
  logic [31:0]       den_r   [N];
  logic [30:0]       quo_r   [N];
  logic [SIDE_W-1:0] side_r  [N];

  genvar k;
  for (k = 0; k < N; k++) begin : g_step
    logic              v_i;
    logic [31:0]       den_i;
    logic [30:0]       quo_i;
    logic [SIDE_W-1:0] side_i;
    logic [32:0]       rem_sh;
    logic [32:0]       diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign den_i  = in_den;
      assign quo_i  = '0;
      assign side_i = in_side;
      assign rem_sh = {1'b0, in_num};
    end else begin : g_next
      assign v_i    = valid_r[k-1];
      assign den_i  = den_r[k-1];
      assign quo_i  = quo_r[k-1];
      assign side_i = side_r[k-1];
      assign rem_sh = {rem_r[k-1], 1'b0};
    end

    assign diff = rem_sh - {1'b0, den_i};
    assign ge   = (rem_sh >= {1'b0, den_i});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[31:0] : rem_sh[31:0];
        den_r[k]  <= den_i;
        quo_r[k]  <= {quo_i[29:0], ge};
        side_r[k] <= side_i;
      end
    end
  end

  assign out_valid = valid_r[N-1];
  assign out_quo   = quo_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

// File: hdl/qr_2x2_gram_schmidt_top.sv
// channel | direction | handshake          | words
// in_     | input     | in_valid/in_stall  | four matrix entries, Q16.16
// out_    | output     | out_valid/out_stall| Q in Q2.30, R in Q16.16, degenerate flag
//
// One word enters per cycle while in_stall is low; the path runs through the two
// bit-per-stage square-root pipelines and the two divider pipelines.
// rst_n is synchronous; it clears the valid bits only.
// Every stage advances together; out_stall on a full output register freezes the
// whole pipeline and raises in_stall in the same cycle.
// DATA_WIDTH: inputs are taken from their low DATA_WIDTH bits, 16 to 32.
module qr_2x2_gram_schmidt_top #(
  parameter int DATA_WIDTH = qr2_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_a_row0_col0,
  input  logic signed [31:0] in_a_row1_col0,
  input  logic signed [31:0] in_a_row0_col1,
  input  logic signed [31:0] in_a_row1_col1,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_q_row0_col0,
  output logic signed [31:0] out_q_row1_col0,
  output logic signed [31:0] out_q_row0_col1,
  output logic signed [31:0] out_q_row1_col1,
  output logic [30:0]        out_r_top_left,
  output logic signed [31:0] out_r_top_right,
  output logic [30:0]        out_r_bottom_right,
  output logic               out_degenerate
);

  localparam int P_W = qr2_pkg::P_W;
  localparam int U_W = qr2_pkg::U_W;
  localparam int SH  = 32 - DATA_WIDTH;
  localparam int FQ  = qr2_pkg::FRAC_Q;
  localparam logic [31:0] NORM_MAX = 32'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
  localparam logic signed [P_W-1:0] P_MAX = P_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
  localparam logic signed [P_W-1:0] P_MIN = -P_MAX - P_W'(1);
  localparam logic signed [37:0] U_CLAMP = 38'sh0FFFFFFFF;

  logic en;
  logic out_valid_r;
  assign in_stall = out_valid_r && out_stall;
  assign en       = !in_stall;

  // stage 0: input register, sign-extended from DATA_WIDTH
  logic         s0_valid_r;
  qr2_pkg::vec_t s0_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s0_v_r.v1x <= $signed(in_a_row0_col0 << SH) >>> SH;
      s0_v_r.v1y <= $signed(in_a_row1_col0 << SH) >>> SH;
      s0_v_r.v2x <= $signed(in_a_row0_col1 << SH) >>> SH;
      s0_v_r.v2y <= $signed(in_a_row1_col1 << SH) >>> SH;
    end
  end

  // stage 1: squares of the first column
  logic          s1_valid_r;
  qr2_pkg::vec_t s1_v_r;
  logic [63:0]   s1_sqx_r, s1_sqy_r;
  logic [31:0]   m1x, m1y;
  assign m1x = qr2_pkg::mag32(s0_v_r.v1x);
  assign m1y = qr2_pkg::mag32(s0_v_r.v1y);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= s0_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_v_r   <= s0_v_r;
      s1_sqx_r <= m1x * m1x;
      s1_sqy_r <= m1y * m1y;
    end
  end

  // stage 2: sum of squares, exact in 64 bits (at most 2^63)
  logic          s2_valid_r;
  qr2_pkg::vec_t s2_v_r;
  logic [63:0]   s2_sum_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_v_r   <= s1_v_r;
      s2_sum_r <= s1_sqx_r + s1_sqy_r;
    end
  end

  // first norm
  logic          sq1_valid;
  logic [31:0]   sq1_root;
  qr2_pkg::vec_t sq1_v;
  qr2_sqrt #(.SIDE_W($bits(qr2_pkg::vec_t))) u_sqrt1 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s2_valid_r), .in_rad(s2_sum_r), .in_side(s2_v_r),
    .out_valid(sq1_valid), .out_root(sq1_root), .out_side(sq1_v)
  );

  // first unit vector
  qr2_pkg::d1_side_t d1_in, d1x_side;
  logic              d1x_valid, d1y_valid, d1y_sign;
  logic [30:0]       d1x_quo, d1y_quo;
  assign d1_in.n1  = sq1_root;
  assign d1_in.s1x = sq1_v.v1x[31];
  assign d1_in.v2x = sq1_v.v2x;
  assign d1_in.v2y = sq1_v.v2y;

  qr2_div #(.SIDE_W($bits(qr2_pkg::d1_side_t))) u_div1x (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(sq1_valid), .in_num(qr2_pkg::mag32(sq1_v.v1x)), .in_den(sq1_root),
    .in_side(d1_in),
    .out_valid(d1x_valid), .out_quo(d1x_quo), .out_side(d1x_side)
  );
  qr2_div #(.SIDE_W(1)) u_div1y (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(sq1_valid), .in_num(qr2_pkg::mag32(sq1_v.v1y)), .in_den(sq1_root),
    .in_side(sq1_v.v1y[31]),
    .out_valid(d1y_valid), .out_quo(d1y_quo), .out_side(d1y_sign)
  );

  // stage 3: signed e1
  logic               s3_valid_r;
  logic signed [31:0] s3_e1x_r, s3_e1y_r, s3_v2x_r, s3_v2y_r;
  logic [31:0]        s3_n1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= d1x_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_e1x_r <= qr2_pkg::unit_fix(d1x_side.s1x, d1x_quo, d1x_side.n1 == 32'd0);
      s3_e1y_r <= qr2_pkg::unit_fix(d1y_sign, d1y_quo, d1x_side.n1 == 32'd0);
      s3_n1_r  <= d1x_side.n1;
      s3_v2x_r <= d1x_side.v2x;
      s3_v2y_r <= d1x_side.v2y;
    end
  end

  // stage 4: dot product terms
  logic               s4_valid_r;
  logic signed [31:0] s4_e1x_r, s4_e1y_r, s4_v2x_r, s4_v2y_r;
  logic [31:0]        s4_n1_r;
  logic signed [63:0] s4_px_r, s4_py_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s4_valid_r <= s3_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_px_r  <= s3_v2x_r * s3_e1x_r;
      s4_py_r  <= s3_v2y_r * s3_e1y_r;
      s4_e1x_r <= s3_e1x_r;
      s4_e1y_r <= s3_e1y_r;
      s4_n1_r  <= s3_n1_r;
      s4_v2x_r <= s3_v2x_r;
      s4_v2y_r <= s3_v2y_r;
    end
  end

  // stage 5: projection, floored to Q16.16
  logic                  s5_valid_r;
  logic signed [31:0]    s5_e1x_r, s5_e1y_r, s5_v2x_r, s5_v2y_r;
  logic [31:0]           s5_n1_r;
  logic signed [P_W-1:0] s5_p_r;
  logic signed [64:0]    dot;
  assign dot = 65'(s4_px_r) + 65'(s4_py_r);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (en) begin
      s5_valid_r <= s4_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s5_p_r   <= P_W'(dot >>> FQ);
      s5_e1x_r <= s4_e1x_r;
      s5_e1y_r <= s4_e1y_r;
      s5_n1_r  <= s4_n1_r;
      s5_v2x_r <= s4_v2x_r;
      s5_v2y_r <= s4_v2y_r;
    end
  end

  // stage 6: p * e1
  logic                      s6_valid_r;
  logic signed [31:0]        s6_e1x_r, s6_e1y_r, s6_v2x_r, s6_v2y_r;
  logic [31:0]               s6_n1_r;
  logic signed [P_W-1:0]     s6_p_r;
  logic signed [P_W+31:0]    s6_qx_r, s6_qy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_valid_r <= 1'b0;
    end else if (en) begin
      s6_valid_r <= s5_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s6_qx_r  <= s5_p_r * s5_e1x_r;
      s6_qy_r  <= s5_p_r * s5_e1y_r;
      s6_p_r   <= s5_p_r;
      s6_e1x_r <= s5_e1x_r;
      s6_e1y_r <= s5_e1y_r;
      s6_n1_r  <= s5_n1_r;
      s6_v2x_r <= s5_v2x_r;
      s6_v2y_r <= s5_v2y_r;
    end
  end

  // stage 7: residual, clamped
  logic                  s7_valid_r;
  logic signed [31:0]    s7_e1x_r, s7_e1y_r;
  logic [31:0]           s7_n1_r;
  logic signed [P_W-1:0] s7_p_r;
  logic signed [U_W-1:0] s7_ux_r, s7_uy_r;
  logic signed [37:0]    ux_full, uy_full, ux_cl, uy_cl;
  assign ux_full = 38'(s6_v2x_r) - 38'(s6_qx_r >>> FQ);
  assign uy_full = 38'(s6_v2y_r) - 38'(s6_qy_r >>> FQ);
  assign ux_cl = (ux_full > U_CLAMP) ? U_CLAMP : ((ux_full < -U_CLAMP) ? -U_CLAMP : ux_full);
  assign uy_cl = (uy_full > U_CLAMP) ? U_CLAMP : ((uy_full < -U_CLAMP) ? -U_CLAMP : uy_full);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_valid_r <= 1'b0;
    end else if (en) begin
      s7_valid_r <= s6_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s7_ux_r  <= U_W'(ux_cl);
      s7_uy_r  <= U_W'(uy_cl);
      s7_p_r   <= s6_p_r;
      s7_e1x_r <= s6_e1x_r;
      s7_e1y_r <= s6_e1y_r;
      s7_n1_r  <= s6_n1_r;
    end
  end

  // stage 8: squares of the residual
  logic                  s8_valid_r;
  qr2_pkg::s2_side_t     s8_side_r;
  logic [63:0]           s8_sqx_r, s8_sqy_r;
  logic [U_W-1:0]        ux_abs, uy_abs;
  assign ux_abs = s7_ux_r[U_W-1] ? U_W'(-s7_ux_r) : U_W'(s7_ux_r);
  assign uy_abs = s7_uy_r[U_W-1] ? U_W'(-s7_uy_r) : U_W'(s7_uy_r);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_valid_r <= 1'b0;
    end else if (en) begin
      s8_valid_r <= s7_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s8_sqx_r      <= ux_abs[31:0] * ux_abs[31:0];
      s8_sqy_r      <= uy_abs[31:0] * uy_abs[31:0];
      s8_side_r.mux <= ux_abs[31:0];
      s8_side_r.muy <= uy_abs[31:0];
      s8_side_r.sx  <= s7_ux_r[U_W-1];
      s8_side_r.sy  <= s7_uy_r[U_W-1];
      s8_side_r.e1x <= s7_e1x_r;
      s8_side_r.e1y <= s7_e1y_r;
      s8_side_r.n1  <= s7_n1_r;
      s8_side_r.p   <= s7_p_r;
    end
  end

  // stage 9: saturating sum
  logic              s9_valid_r;
  qr2_pkg::s2_side_t s9_side_r;
  logic [63:0]       s9_sum_r;
  logic [64:0]       sum2;
  assign sum2 = {1'b0, s8_sqx_r} + {1'b0, s8_sqy_r};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_valid_r <= 1'b0;
    end else if (en) begin
      s9_valid_r <= s8_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s9_sum_r  <= sum2[64] ? '1 : sum2[63:0];
      s9_side_r <= s8_side_r;
    end
  end

  // second norm
  logic              sq2_valid;
  logic [31:0]       sq2_root;
  qr2_pkg::s2_side_t sq2_side;
  qr2_sqrt #(.SIDE_W($bits(qr2_pkg::s2_side_t))) u_sqrt2 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s9_valid_r), .in_rad(s9_sum_r), .in_side(s9_side_r),
    .out_valid(sq2_valid), .out_root(sq2_root), .out_side(sq2_side)
  );

  // second unit vector
  qr2_pkg::d2_side_t d2_in, d2x_side;
  logic              d2x_valid, d2y_valid, d2y_sign;
  logic [30:0]       d2x_quo, d2y_quo;
  assign d2_in.sx  = sq2_side.sx;
  assign d2_in.e1x = sq2_side.e1x;
  assign d2_in.e1y = sq2_side.e1y;
  assign d2_in.n1  = sq2_side.n1;
  assign d2_in.n2  = sq2_root;
  assign d2_in.p   = sq2_side.p;

  qr2_div #(.SIDE_W($bits(qr2_pkg::d2_side_t))) u_div2x (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(sq2_valid), .in_num(sq2_side.mux), .in_den(sq2_root), .in_side(d2_in),
    .out_valid(d2x_valid), .out_quo(d2x_quo), .out_side(d2x_side)
  );
  qr2_div #(.SIDE_W(1)) u_div2y (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(sq2_valid), .in_num(sq2_side.muy), .in_den(sq2_root), .in_side(sq2_side.sy),
    .out_valid(d2y_valid), .out_quo(d2y_quo), .out_side(d2y_sign)
  );

  // output register
  logic signed [31:0] q00_r, q10_r, q01_r, q11_r, rtr_r;
  logic [30:0]        rtl_r, rbr_r;
  logic               degen_r;
  logic               n2_zero;
  assign n2_zero = (d2x_side.n2 == 32'd0);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d2x_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      q00_r   <= d2x_side.e1x;
      q10_r   <= d2x_side.e1y;
      q01_r   <= qr2_pkg::unit_fix(d2x_side.sx, d2x_quo, n2_zero);
      q11_r   <= qr2_pkg::unit_fix(d2y_sign, d2y_quo, n2_zero);
      rtl_r   <= 31'((d2x_side.n1 > NORM_MAX) ? NORM_MAX : d2x_side.n1);
      rbr_r   <= 31'((d2x_side.n2 > NORM_MAX) ? NORM_MAX : d2x_side.n2);
      rtr_r   <= 32'((d2x_side.p > P_MAX) ? P_MAX : ((d2x_side.p < P_MIN) ? P_MIN : d2x_side.p));
      degen_r <= (d2x_side.n1 == 32'd0) || n2_zero;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_q_row0_col0    = q00_r;
  assign out_q_row1_col0    = q10_r;
  assign out_q_row0_col1    = q01_r;
  assign out_q_row1_col1    = q11_r;
  assign out_r_top_left     = rtl_r;
  assign out_r_top_right    = rtr_r;
  assign out_r_bottom_right = rbr_r;
  assign out_degenerate     = degen_r;

  a_div_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    (d1x_valid == d1y_valid) && (d2x_valid == d2y_valid))
    else $error("divider lanes out of step");

  a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !degen_r |-> (rtl_r != 31'd0) && (rbr_r != 31'd0))
    else $error("zero norm without degenerate flag");

  a_zero_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (rtl_r == 31'd0) |-> degen_r && (q00_r == 32'sd0) && (q10_r == 32'sd0))
    else $error("zero first column gives non-zero unit vector");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (q01_r <= 32'sh40000000) && (q01_r >= -32'sh40000000)
                 && (q00_r <= 32'sh40000000) && (q00_r >= -32'sh40000000))
    else $error("unit component beyond one");

endmodule
